/* hw/rtl/rqsf_pkg.sv */
// Package: shared types, widths and request codes of the run queue.
`default_nettype none
package rqsf_pkg;

    // Field widths of the request and result words
    localparam int HANDLE_W = 32;
    localparam int MODE_W   = 2;
    localparam int LEN_W    = 11;

    // Default ring depth
    localparam int DEFAULT_QUEUE_DEPTH = 1024;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STEAL = 2'd3;

    // Result word
    typedef struct packed {
        logic                accepted;
        logic                popped_valid;
        logic [HANDLE_W-1:0] popped_handle;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/rqsf_if.sv */
// Interfaces: request channel and result channel of the run queue.
`default_nettype none
interface rqsf_in_if;
    logic                           valid;
    logic                           ready;
    logic [rqsf_pkg::MODE_W-1:0]    mode;
    logic [rqsf_pkg::HANDLE_W-1:0]  entity_handle;
    logic                           no_steal;
    logic                           batch_start;
    logic [rqsf_pkg::LEN_W-1:0]     batch_length;

    modport source (output valid, mode, entity_handle, no_steal, batch_start, batch_length,
                    input ready);
    modport sink   (input valid, mode, entity_handle, no_steal, batch_start, batch_length,
                    output ready);
endinterface

interface rqsf_out_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic                           popped_valid;
    logic [rqsf_pkg::HANDLE_W-1:0]  popped_handle;

    modport source (output valid, accepted, popped_valid, popped_handle, input ready);
    modport sink   (input valid, accepted, popped_valid, popped_handle, output ready);
endinterface
`default_nettype wire

/* hw/rtl/run_queue_with_steal_flag_top.sv */
// Top level of the bounded run queue of task handles with no-steal marks.
//
// Each request word (push, batch element, pop or steal) gives exactly one result
// word. Handles and their no-steal marks live in one ring RAM of QUEUE_DEPTH
// entries with a registered read; RAM contents are not cleared at reset and no
// entry is read before it was written. Pushes, batch elements and pop or steal on
// an empty ring can be accepted every cycle while the result buffer has room. A pop
// or steal on a non-empty ring passes a read state: the head entry is read from the
// RAM and its mark is checked when the read data returns. A two-word result buffer
// lets new requests be accepted while earlier results wait on the output.
`default_nettype none
module run_queue_with_steal_flag_top #(
    parameter int QUEUE_DEPTH = rqsf_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rqsf_in_if.sink     i_in,
    rqsf_out_if.source  o_out
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int WORD_W = rqsf_pkg::HANDLE_W + 1;

    logic              w_room;
    logic              w_wr_en;
    logic [PTR_W-1:0]  w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [PTR_W-1:0]  w_rd_addr;
    logic [WORD_W-1:0] w_rd_data;
    logic              w_res_push;
    rqsf_pkg::t_result w_res;

    // ring storage: {no_steal, handle}
    rqsf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    rqsf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_room     (w_room),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    rqsf_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

/* hw/rtl/rqsf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rqsf_ram #(
    parameter int WIDTH  = rqsf_pkg::HANDLE_W + 1,
    parameter int DEPTH  = rqsf_pkg::DEFAULT_QUEUE_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rqsf_outbuf.sv */
// Two-word result buffer between the queue control and the result channel.
`default_nettype none
module rqsf_outbuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rqsf_pkg::t_result i_res,
    output logic                   o_room,
    rqsf_out_if.source             o_out
);

    rqsf_pkg::t_result r_slot [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_cnt;
    logic              w_pop;

    assign w_pop  = o_out.valid && o_out.ready;
    assign o_room = (r_cnt != 2'd2);

    // result word to the channel
    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.accepted      = r_slot[r_rptr].accepted;
    assign o_out.popped_valid  = r_slot[r_rptr].popped_valid;
    assign o_out.popped_handle = r_slot[r_rptr].popped_handle;

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_res;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2)
        else $error("result word pushed into full buffer");

    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.accepted)
            && $stable(o_out.popped_valid) && $stable(o_out.popped_handle)))
        else $error("result word changed while stalled");

endmodule
`default_nettype wire

/* hw/rtl/rqsf_ctrl.sv */
// Queue control: pointers, occupancy, batch reservation and read-modify of the ring RAM.
`default_nettype none
module rqsf_ctrl #(
    parameter int QUEUE_DEPTH = rqsf_pkg::DEFAULT_QUEUE_DEPTH,
    localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    rqsf_in_if.sink                         i_in,
    input  wire logic                       i_room,
    output logic                            o_wr_en,
    output logic [PTR_W-1:0]                o_wr_addr,
    output logic [rqsf_pkg::HANDLE_W:0]     o_wr_data,
    output logic                            o_rd_en,
    output logic [PTR_W-1:0]                o_rd_addr,
    input  wire logic [rqsf_pkg::HANDLE_W:0] i_rd_data,
    output logic                            o_res_push,
    output rqsf_pkg::t_result               o_res
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W = rqsf_pkg::LEN_W;
    localparam int CMP_W = ((OCC_W > LEN_W) ? OCC_W : LEN_W) + 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic             r_state,     n_state;
    logic             r_is_pop,    n_is_pop;
    logic [PTR_W-1:0] r_wr_ptr,    n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr,    n_rd_ptr;
    logic [OCC_W-1:0] r_occ,       n_occ;
    logic [LEN_W-1:0] r_batch_rem, n_batch_rem;
    logic             r_batch_rej, n_batch_rej;

    logic             w_take;
    logic [CMP_W-1:0] w_occ_ext;
    logic [CMP_W-1:0] w_res_ext;
    logic [CMP_W-1:0] w_len_ext;
    logic             w_push_ok;
    logic             w_batch_ok;
    logic             w_room_left;
    logic [PTR_W-1:0] w_wr_next;
    logic [PTR_W-1:0] w_rd_next;

    assign i_in.ready = (r_state == ST_IDLE) && i_room;
    assign w_take     = i_in.valid && i_in.ready;

    // fit checks against free space; reserved batch space counts as used for single pushes
    assign w_occ_ext   = CMP_W'(r_occ);
    assign w_res_ext   = r_batch_rej ? '0 : CMP_W'(r_batch_rem);
    assign w_len_ext   = CMP_W'(i_in.batch_length);
    assign w_push_ok   = (w_occ_ext + w_res_ext) < DEPTH_C;
    assign w_batch_ok  = (i_in.batch_length != '0) && ((w_occ_ext + w_len_ext) <= DEPTH_C);
    assign w_room_left = w_occ_ext < DEPTH_C;

    // pointer wrap
    assign w_wr_next = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
    assign w_rd_next = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);

    assign o_wr_addr = r_wr_ptr;
    assign o_wr_data = {i_in.no_steal, i_in.entity_handle};
    assign o_rd_addr = r_rd_ptr;

    // request decode and state update
    always_comb begin
        n_state     = r_state;
        n_is_pop    = r_is_pop;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_occ       = r_occ;
        n_batch_rem = r_batch_rem;
        n_batch_rej = r_batch_rej;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    case (i_in.mode)
                        rqsf_pkg::MODE_PUSH: begin
                            o_res_push = 1'b1;
                            if (w_push_ok) begin
                                o_wr_en        = 1'b1;
                                n_wr_ptr       = w_wr_next;
                                n_occ          = r_occ + OCC_W'(1);
                                o_res.accepted = 1'b1;
                            end
                        end
                        rqsf_pkg::MODE_BATCH: begin
                            o_res_push = 1'b1;
                            if (i_in.batch_start) begin
                                n_batch_rem = (i_in.batch_length != '0) ?
                                              i_in.batch_length - LEN_W'(1) : '0;
                                n_batch_rej = !w_batch_ok;
                                if (w_batch_ok) begin
                                    o_wr_en        = 1'b1;
                                    n_wr_ptr       = w_wr_next;
                                    n_occ          = r_occ + OCC_W'(1);
                                    o_res.accepted = 1'b1;
                                end
                            end else if (r_batch_rem != '0) begin
                                n_batch_rem = r_batch_rem - LEN_W'(1);
                                if (!r_batch_rej && w_room_left) begin
                                    o_wr_en        = 1'b1;
                                    n_wr_ptr       = w_wr_next;
                                    n_occ          = r_occ + OCC_W'(1);
                                    o_res.accepted = 1'b1;
                                end
                            end
                        end
                        rqsf_pkg::MODE_POP, rqsf_pkg::MODE_STEAL: begin
                            if (r_occ == '0) begin
                                o_res_push = 1'b1;
                            end else begin
                                o_rd_en  = 1'b1;
                                n_state  = ST_READ;
                                n_is_pop = (i_in.mode == rqsf_pkg::MODE_POP);
                            end
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // head word is back from the RAM: a marked head stays on steal
                o_res_push = 1'b1;
                n_state    = ST_IDLE;
                if (r_is_pop || !i_rd_data[rqsf_pkg::HANDLE_W]) begin
                    o_res.popped_valid  = 1'b1;
                    o_res.popped_handle = i_rd_data[rqsf_pkg::HANDLE_W-1:0];
                    n_rd_ptr            = w_rd_next;
                    n_occ               = r_occ - OCC_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_is_pop    <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_occ       <= '0;
            r_batch_rem <= '0;
            r_batch_rej <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_is_pop    <= n_is_pop;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_occ       <= n_occ;
            r_batch_rem <= n_batch_rem;
            r_batch_rej <= n_batch_rej;
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_occ) <= DEPTH_C)
        else $error("occupancy above ring depth");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |-> r_occ != '0)
        else $error("head read issued on empty ring");

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |=> r_state == ST_IDLE)
        else $error("head read did not finish in one cycle");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == ST_IDLE && !o_rd_en))
        else $error("ring write overlaps a head read");

endmodule
`default_nettype wire

/* tb/run_queue_with_steal_flag_top_tb.sv */
// Testbench: self-checking traffic and ring tracker for the run queue with no-steal marks.
module run_queue_with_steal_flag_top_tb;
    import rqsf_pkg::*;

    localparam int DEPTH         = DEFAULT_QUEUE_DEPTH;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 3000;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic                no_steal;
        logic                start;
        logic [LEN_W-1:0]    len;
    } t_request;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rqsf_in_if  req_if ();
    rqsf_out_if res_if ();

    run_queue_with_steal_flag_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the ring and its batch bookkeeping
    logic [HANDLE_W-1:0] ring_handle [DEPTH];
    logic                ring_mark   [DEPTH];
    int                  wr_idx        = 0;
    int                  rd_idx        = 0;
    int                  ring_count    = 0;
    int                  batch_left    = 0;
    bit                  batch_refused = 1'b0;

    t_result pending_results [$];
    int      error_count = 0;
    int      quiet_cycles = 0;
    int      idle_pct = 0;
    logic    hold_req = 1'b0;

    function automatic void ring_store(logic [HANDLE_W-1:0] handle, logic mark);
        ring_handle[wr_idx] = handle;
        ring_mark[wr_idx]   = mark;
        wr_idx = (wr_idx + 1) % DEPTH;
        ring_count++;
    endfunction

    // Expected result word for one accepted request; updates the shadow ring
    function automatic t_result run_queue_step(t_request w);
        t_result r;
        int      reserved;
        r = '0;
        reserved = batch_refused ? 0 : batch_left;
        case (w.mode)
            MODE_PUSH: begin
                if (ring_count + reserved < DEPTH) begin
                    ring_store(w.handle, w.no_steal);
                    r.accepted = 1'b1;
                end
            end
            MODE_BATCH: begin
                if (w.start) begin
                    // whole batch must fit the free space exactly or better
                    if (w.len != 0 && ring_count + int'(w.len) <= DEPTH) begin
                        batch_refused = 1'b0;
                        batch_left    = int'(w.len) - 1;
                        ring_store(w.handle, w.no_steal);
                        r.accepted = 1'b1;
                    end else begin
                        batch_refused = 1'b1;
                        batch_left    = (w.len != 0) ? int'(w.len) - 1 : 0;
                    end
                end else if (batch_left != 0) begin
                    batch_left--;
                    if (!batch_refused && ring_count < DEPTH) begin
                        ring_store(w.handle, w.no_steal);
                        r.accepted = 1'b1;
                    end
                end
            end
            default: begin
                // pop always takes the head; steal only an unmarked head
                if (ring_count != 0 && (w.mode == MODE_POP || !ring_mark[rd_idx])) begin
                    r.popped_valid  = 1'b1;
                    r.popped_handle = ring_handle[rd_idx];
                    rd_idx = (rd_idx + 1) % DEPTH;
                    ring_count--;
                end
            end
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    // Offer one word, wait for the handshake, then record its expected result
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
                             input logic no_steal, input logic start,
                             input logic [LEN_W-1:0] len);
        t_request w;
        int       gap;
        gap = ($urandom_range(99) < idle_pct) ? pick_gap_len() : 0;
        repeat (gap) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.mode          <= mode;
        req_if.entity_handle <= handle;
        req_if.no_steal      <= no_steal;
        req_if.batch_start   <= start;
        req_if.batch_length  <= len;
        do @(posedge i_clk); while (!req_if.ready);
        w = '{mode: mode, handle: handle, no_steal: no_steal, start: start, len: len};
        pending_results.push_back(run_queue_step(w));
    endtask

    // Word with random filler in every field but the mode and the batch start flag
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic start);
        send_word(mode, $urandom(), 1'($urandom_range(1)), start, 11'($urandom_range(2047)));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Empty the ring, steals first so marked heads get exercised too
    task automatic drain_ring();
        while (ring_count != 0) begin
            send_op(MODE_STEAL, 1'($urandom_range(1)));
            if (ring_count != 0) send_op(MODE_POP, 1'($urandom_range(1)));
        end
        wait_drained();
    endtask

    // Pop and steal on an empty ring, stray batch words, zero-length batch
    task automatic test_empty_ring();
        idle_pct = 30;
        send_word(MODE_POP, 32'h0, 1'b0, 1'b0, 11'h0);
        send_word(MODE_STEAL, 32'hFFFF_FFFF, 1'b1, 1'b1, 11'h7FF);
        send_word(MODE_BATCH, 32'h1234_5678, 1'b0, 1'b0, 11'h3);
        send_word(MODE_BATCH, 32'h8765_4321, 1'b1, 1'b1, 11'h0);
        send_word(MODE_BATCH, 32'h0BAD_F00D, 1'b0, 1'b0, 11'h1);
        wait_drained();
    endtask

    // Extreme handles; steal skips nothing and stops at a marked head
    task automatic test_push_pop_steal();
        idle_pct = 30;
        send_word(MODE_PUSH, 32'h0, 1'b0, 1'b0, 11'h0);
        send_word(MODE_PUSH, 32'hFFFF_FFFF, 1'b1, 1'b1, 11'h7FF);
        send_word(MODE_PUSH, 32'hA5A5_5A5A, 1'b0, 1'b0, 11'h400);
        send_word(MODE_STEAL, 32'h0, 1'b0, 1'b0, 11'h0);
        send_word(MODE_STEAL, 32'h0, 1'b0, 1'b0, 11'h0);
        send_word(MODE_POP, 32'h0, 1'b0, 1'b0, 11'h0);
        send_word(MODE_STEAL, 32'h0, 1'b0, 1'b0, 11'h0);
        wait_drained();
    endtask

    // Batch framing: full batch, overrun, push inside a batch, restart, refusal
    task automatic test_batch_rules();
        idle_pct = 30;
        send_word(MODE_BATCH, 32'h1000_0001, 1'b0, 1'b1, 11'd3);
        send_word(MODE_BATCH, 32'h1000_0002, 1'b1, 1'b0, 11'd0);
        send_word(MODE_BATCH, 32'h1000_0003, 1'b0, 1'b0, 11'd9);
        send_word(MODE_BATCH, 32'h1000_0004, 1'b0, 1'b0, 11'd0);
        send_word(MODE_BATCH, 32'h2000_0001, 1'b1, 1'b1, 11'd4);
        send_word(MODE_BATCH, 32'h2000_0002, 1'b0, 1'b0, 11'd4);
        send_word(MODE_PUSH, 32'h3000_0001, 1'b0, 1'b0, 11'd0);
        send_word(MODE_BATCH, 32'h4000_0001, 1'b0, 1'b1, 11'd2);
        send_word(MODE_BATCH, 32'h4000_0002, 1'b1, 1'b0, 11'd2);
        send_word(MODE_BATCH, 32'h5000_0001, 1'b0, 1'b1, 11'h7FF);
        send_word(MODE_BATCH, 32'h5000_0002, 1'b0, 1'b0, 11'h7FF);
        send_word(MODE_BATCH, 32'h5000_0003, 1'b1, 1'b0, 11'h7FF);
        wait_drained();
    endtask

    // Reserved batch space blocks single pushes; the batch fit is exact
    task automatic test_batch_reserve();
        idle_pct = 10;
        drain_ring();
        // whole ring reserved by one batch: pushes refused while it is open
        send_word(MODE_BATCH, $urandom(), 1'b1, 1'b1, 11'd1024);
        send_op(MODE_PUSH, 1'b0);
        send_word(MODE_BATCH, $urandom(), 1'b0, 1'b0, 11'($urandom_range(2047)));
        send_op(MODE_PUSH, 1'b0);
        // one slot too many: refused, reservation dropped
        send_word(MODE_BATCH, $urandom(), 1'b0, 1'b1, 11'd1023);
        send_op(MODE_BATCH, 1'b0);
        send_word(MODE_PUSH, $urandom(), 1'b1, 1'b0, 11'd0);
        // exact fit into the remaining space
        send_word(MODE_BATCH, $urandom(), 1'b0, 1'b1, 11'd1021);
        send_op(MODE_PUSH, 1'b0);
        send_op(MODE_STEAL, 1'b0);
        send_op(MODE_PUSH, 1'b0);
        send_word(MODE_BATCH, $urandom(), 1'b0, 1'b1, 11'd1025);
        send_op(MODE_PUSH, 1'b0);
        drain_ring();
    endtask

    // Receiver holds off long enough for the block to back up its input
    task automatic test_output_backpressure();
        idle_pct = 0;
        hold_req <= ~hold_req;
        repeat (24) begin
            send_op(MODE_PUSH, 1'($urandom_range(1)));
            send_op(MODE_POP, 1'($urandom_range(1)));
        end
        wait_drained();
    endtask

    // Random mix of pushes, framed batches, stray batch words, pops and steals
    task automatic test_random_traffic(input int n_items, input int gap_pct);
        int sent;
        int pick;
        int len;
        int n_elem;
        idle_pct = gap_pct;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 28) begin
                send_word(MODE_PUSH, $urandom(), 1'($urandom_range(9) < 3),
                          1'($urandom_range(1)), 11'($urandom_range(2047)));
                sent++;
            end else if (pick < 48) begin
                pick = $urandom_range(9);
                if (pick < 7)       len = $urandom_range(1, 6);
                else if (pick == 7) len = 0;
                else if (pick == 8) len = $urandom_range(1025, 2047);
                else                len = $urandom_range(7, 20);
                n_elem = (len == 0) ? 0 : len - 1;
                if (n_elem > 20) n_elem = $urandom_range(1, 4);
                pick = $urandom_range(99);
                // sometimes cut the batch short or run past its length
                if (pick < 15 && n_elem > 0) n_elem = $urandom_range(0, n_elem - 1);
                else if (pick < 25)          n_elem += $urandom_range(1, 2);
                send_word(MODE_BATCH, $urandom(), 1'($urandom_range(9) < 3), 1'b1, 11'(len));
                repeat (n_elem) send_word(MODE_BATCH, $urandom(), 1'($urandom_range(9) < 3),
                                          1'b0, 11'($urandom_range(2047)));
                sent += 1 + n_elem;
            end else if (pick < 50) begin
                send_op(MODE_BATCH, 1'b0);
                sent++;
            end else if (pick < 76) begin
                send_op(MODE_POP, 1'($urandom_range(1)));
                sent++;
            end else begin
                send_op(MODE_STEAL, 1'($urandom_range(1)));
                sent++;
            end
        end
        wait_drained();
    endtask

    // Result receiver: random stalls plus a long hold-off on request
    initial begin : result_sink
        logic seen_hold;
        int   stall;
        seen_hold    = 1'b0;
        stall        = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != seen_hold) begin
                seen_hold = hold_req;
                stall     = HOLD_CYCLES;
            end else if (stall == 0 && $urandom_range(99) < idle_pct) begin
                stall = pick_gap_len();
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Compare each delivered result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{accepted: res_if.accepted, popped_valid: res_if.popped_valid,
                    popped_handle: res_if.popped_handle};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result acc=%b vld=%b handle=%h", $realtime,
                         got.accepted, got.popped_valid, got.popped_handle);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: exp acc=%b vld=%b h=%h, got acc=%b vld=%b h=%h",
                             $realtime, want.accepted, want.popped_valid, want.popped_handle,
                             got.accepted, got.popped_valid, got.popped_handle);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_PUSH;
        req_if.entity_handle = '0;
        req_if.no_steal      = 1'b0;
        req_if.batch_start   = 1'b0;
        req_if.batch_length  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_ring();
        test_push_pop_steal();
        test_batch_rules();
        test_batch_reserve();
        test_output_backpressure();
        test_random_traffic(80, 0);
        test_random_traffic(110, 30);
        test_random_traffic(110, 70);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
